// ===== sv/stid_pkg.sv =====
// Package for the sorted table: sizes, operation and status codes, item and control types.
// Used by every module of the sorted table; depends on nothing else.
package stid_pkg;

    localparam int DEPTH = 128;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDXW  = 7;
    localparam int CMPW  = (CW > IDXW) ? CW : IDXW;
    localparam int GRP   = 8;
    localparam int NGRP  = (DEPTH + GRP - 1) / GRP;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_APPLY
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] value;
        logic [IDXW-1:0]    index;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [7:0]         entry_count;
    } t_out;

    typedef struct packed {
        logic               ins_en;
        logic               del_en;
        logic               op_read;
        logic               op_del;
        logic signed [31:0] value;
        logic [IDXW-1:0]    idx;
        logic [CW-1:0]      count;
    } t_cell_ctl;

    typedef struct packed {
        logic        hit;
        logic [31:0] data;
    } t_part;

endpackage

// ===== sv/stid_cell.sv =====
// One slot of the sorted table: holds an entry, compares it with the operand and shifts.
// Depends on stid_pkg.
module stid_cell (
    input  logic                       i_clk,
    input  logic [stid_pkg::PW-1:0]    i_pos,
    input  stid_pkg::t_cell_ctl        i_ctl,
    input  logic [31:0]                i_left_entry,
    input  logic                       i_left_gt,
    input  logic [31:0]                i_right_entry,
    output logic [31:0]                o_entry,
    output logic                       o_gt,
    output stid_pkg::t_part            o_part
);
    import stid_pkg::*;

    logic [31:0] r_entry;
    logic [31:0] n_entry;
    logic        w_valid;
    logic        w_ge;

    assign w_valid = CW'(i_pos) < i_ctl.count;
    assign o_gt    = !w_valid || ($signed(r_entry) > $signed(i_ctl.value));
    assign w_ge    = w_valid && ($signed(r_entry) >= $signed(i_ctl.value));
    assign o_entry = r_entry;

    assign o_part.hit  = i_ctl.op_del && w_valid && (r_entry == i_ctl.value);
    assign o_part.data = (i_ctl.op_read && (CMPW'(i_pos) == CMPW'(i_ctl.idx))) ? r_entry : '0;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_en && o_gt) begin
            n_entry = i_left_gt ? i_left_entry : i_ctl.value;
        end else if (i_ctl.del_en && w_ge) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== sv/stid_or_tree.sv =====
// Two-stage registered OR tree that gathers the read data and match flags of all slots.
// Depends on stid_pkg.
module stid_or_tree (
    input  logic            i_clk,
    input  stid_pkg::t_part i_part [stid_pkg::DEPTH],
    output stid_pkg::t_part o_part
);
    import stid_pkg::*;

    t_part r_grp [NGRP];
    t_part n_grp [NGRP];
    t_part r_all;
    t_part n_all;

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (g * GRP + j < DEPTH) begin
                    n_grp[g] = n_grp[g] | i_part[g * GRP + j];
                end
            end
        end
    end

    always_comb begin
        n_all = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_all = n_all | r_grp[g];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_all <= n_all;
    end

    assign o_part = r_all;

endmodule

// ===== sv/sorted_table_insert_delete.sv =====
// Top level of the sorted table: a row of compare-and-shift slots, an OR tree and the sequencer.
// Depends on stid_pkg, stid_cell and stid_or_tree.
//
//   channel | valid       | stall       | payload
//   input   | i_in_valid  | o_in_stall  | i_in  (operation, value, index)
//   output  | o_out_valid | i_out_stall | o_out (status, read_value, entry_count)
//
// Each item passes through accept, slot compare, OR tree, then update and result; the
// two registered stages of the OR tree find a match or the read data for the update.
// Reset empties the table at once; the entries themselves are not cleared.
// A waiting result does not block the next accept; its update waits until the result is taken.
module sorted_table_insert_delete (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  stid_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output stid_pkg::t_out o_out
);
    import stid_pkg::*;

    t_state        r_state;
    t_state        n_state;
    t_in           r_in;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out          r_out;
    t_out          n_out;
    logic          w_apply;
    logic          w_ins_en;
    logic          w_del_en;
    t_cell_ctl     w_ctl;
    t_part         w_tree;
    logic [31:0]   w_entry [DEPTH];
    logic          w_gt    [DEPTH];
    t_part         w_part  [DEPTH];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign w_apply     = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);

    assign w_ctl.ins_en  = w_ins_en;
    assign w_ctl.del_en  = w_del_en;
    assign w_ctl.op_read = (r_in.operation == OP_READ);
    assign w_ctl.op_del  = (r_in.operation == OP_DELETE);
    assign w_ctl.value   = r_in.value;
    assign w_ctl.idx     = r_in.index;
    assign w_ctl.count   = r_count;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [31:0] w_left_entry;
        logic        w_left_gt;
        logic [31:0] w_right_entry;

        if (k == 0) begin : g_first
            assign w_left_entry = '0;
            assign w_left_gt    = 1'b0;
        end else begin : g_mid
            assign w_left_entry = w_entry[k-1];
            assign w_left_gt    = w_gt[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right_entry = w_entry[k];
        end else begin : g_inner
            assign w_right_entry = w_entry[k+1];
        end

        stid_cell u_cell (
            .i_clk         (i_clk),
            .i_pos         (PW'(k)),
            .i_ctl         (w_ctl),
            .i_left_entry  (w_left_entry),
            .i_left_gt     (w_left_gt),
            .i_right_entry (w_right_entry),
            .o_entry       (w_entry[k]),
            .o_gt          (w_gt[k]),
            .o_part        (w_part[k])
        );
    end

    stid_or_tree u_tree (
        .i_clk  (i_clk),
        .i_part (w_part),
        .o_part (w_tree)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        w_ins_en    = 1'b0;
        w_del_en    = 1'b0;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_RED;
            end
            S_RED: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_apply) begin
                    n_out.status     = ST_DONE;
                    n_out.read_value = '0;
                    case (r_in.operation)
                        OP_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_out.status = ST_FULL;
                            end else begin
                                w_ins_en = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        OP_DELETE: begin
                            if (!w_tree.hit) begin
                                n_out.status = ST_NOMATCH;
                            end else begin
                                w_del_en = 1'b1;
                                n_count  = r_count - 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (CMPW'(r_in.index) < CMPW'(r_count)) begin
                                n_out.read_value = w_tree.data;
                            end else begin
                                n_out.status = ST_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_out.entry_count = 8'(n_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_out_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_APPLY))
        else $error("A result appeared without an update cycle.");

    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.entry_count == 8'(r_count)))
        else $error("Reported count differs from the table count.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ins_en |=> (r_count == $past(r_count) + 1'b1))
        else $error("An insert did not grow the table by one entry.");

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for sorted_table_insert_delete: random and directed insert, delete
// and read items against a local model of the sorted table, with random gaps and stalls.
// Depends on stid_pkg and the sorted_table_insert_delete RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stid_pkg::*;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam int         N_RANDOM   = 1900;
    localparam int         TAIL_WAIT  = 16;
    localparam int         QUIET_MAX  = 3000;
    localparam int         SHOW_MAX   = 10;

    logic i_clk;
    logic i_rst_n     = 1'b0;
    logic in_valid    = 1'b0;
    logic out_stall   = 1'b0;
    t_in  in_item     = '0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out;

    t_in                op_queue[$];
    t_out               results_due[$];
    logic signed [31:0] held_vals[$];
    logic signed [31:0] tbl_vals[DEPTH];
    int                 tbl_cnt     = 0;
    int                 mismatches  = 0;
    int                 quiet_count = 0;
    int                 in_gap      = 0;
    int                 in_calm     = 0;
    int                 stall_left  = 0;
    int                 out_calm    = 0;
    bit                 in_took     = 1'b0;
    bit                 out_took    = 1'b0;

    sorted_table_insert_delete uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int pause_len(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return $signed(32'($urandom_range(0, 15))) - 32'sd8;
        end
        if (r < 50) begin
            case ($urandom_range(0, 4))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        end
        return $signed(32'($urandom));
    endfunction

    function automatic t_out table_apply(input t_in it);
        t_out r;
        int   k;
        r.status      = ST_DONE;
        r.read_value  = '0;
        case (it.operation)
            OP_INSERT: begin
                if (tbl_cnt >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    k = tbl_cnt;
                    while (k > 0 && tbl_vals[k-1] > $signed(it.value)) begin
                        tbl_vals[k] = tbl_vals[k-1];
                        k--;
                    end
                    tbl_vals[k] = it.value;
                    tbl_cnt++;
                end
            end
            OP_DELETE: begin
                k = 0;
                while (k < tbl_cnt && tbl_vals[k] != $signed(it.value)) begin
                    k++;
                end
                if (k == tbl_cnt) begin
                    r.status = ST_NOMATCH;
                end else begin
                    while (k + 1 < tbl_cnt) begin
                        tbl_vals[k] = tbl_vals[k+1];
                        k++;
                    end
                    tbl_cnt--;
                end
            end
            OP_READ: begin
                if (int'(it.index) < tbl_cnt) begin
                    r.read_value = tbl_vals[it.index];
                end else begin
                    r.status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
        r.entry_count = 8'(tbl_cnt);
        return r;
    endfunction

    task automatic plan(input t_op op, input logic signed [31:0] v, input logic [IDXW-1:0] ix);
        t_in it;
        int  hit;
        it.operation = op;
        it.value     = v;
        it.index     = ix;
        op_queue.push_back(it);
        hit = -1;
        if (op == OP_INSERT && held_vals.size() < DEPTH) begin
            held_vals.push_back(v);
        end else if (op == OP_DELETE) begin
            foreach (held_vals[j]) begin
                if (hit < 0 && held_vals[j] == v) begin
                    hit = j;
                end
            end
            if (hit >= 0) begin
                held_vals.delete(hit);
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input t_out want, input t_out got);
        mismatches++;
        if (mismatches <= SHOW_MAX) begin
            $display("%0t mismatch (%s): want st=%0d rd=%0d cnt=%0d, got st=%0d rd=%0d cnt=%0d",
                     $realtime, what, want.status, want.read_value, want.entry_count,
                     got.status, got.read_value, got.entry_count);
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_took) begin
            if (in_gap > 0) begin
                in_valid <= 1'b0;
                in_gap--;
            end else if (op_queue.size() > 0) begin
                in_item  <= op_queue.pop_front();
                in_valid <= 1'b1;
                if (in_calm > 0) begin
                    in_calm--;
                end else if ($urandom_range(0, 199) == 0) begin
                    in_calm = $urandom_range(100, 300);
                end
                in_gap = pause_len(in_calm > 0);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
            if (out_calm > 0) begin
                out_calm--;
            end else if ($urandom_range(0, 199) == 0) begin
                out_calm = $urandom_range(100, 300);
            end
            stall_left = pause_len(out_calm > 0);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            in_took  = 1'b0;
            out_took = 1'b0;
        end else begin
            in_took  = in_valid && !o_in_stall;
            out_took = o_out_valid && !out_stall;
            if (in_took) begin
                results_due.push_back(table_apply(in_item));
            end
            if (out_took) begin
                if (results_due.size() == 0) begin
                    flag_mismatch("no item outstanding", '0, o_out);
                end else begin
                    want = results_due.pop_front();
                    if (o_out.status !== want.status || o_out.read_value !== want.read_value
                            || o_out.entry_count !== want.entry_count) begin
                        flag_mismatch("field", want, o_out);
                    end
                end
            end
            if (in_took || out_took) begin
                quiet_count = 0;
            end else begin
                quiet_count++;
            end
            if (quiet_count >= QUIET_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int                 kind;
        int                 len;
        int                 r;
        int                 n_rand;
        t_op                op;
        logic signed [31:0] v;
        logic [IDXW-1:0]    ix;

        plan(OP_READ, 32'sd0, 7'd0);
        plan(OP_READ, 32'sd0, 7'd127);
        plan(OP_DELETE, 32'sd5, 7'd0);
        plan(t_op'(OP_UNUSED), 32'sd77, 7'd3);
        plan(OP_INSERT, 32'sd0, 7'd0);
        plan(OP_INSERT, 32'sh7fff_ffff, 7'd0);
        plan(OP_INSERT, 32'sh8000_0000, 7'd0);
        plan(OP_INSERT, 32'sd0, 7'd0);
        plan(OP_INSERT, -32'sd1, 7'd0);
        plan(OP_INSERT, 32'sd1, 7'd0);
        for (int j = 0; j < 7; j++) begin
            plan(OP_READ, 32'sd0, 7'(j));
        end
        plan(OP_DELETE, 32'sd0, 7'd0);
        plan(OP_DELETE, 32'sd12345, 7'd0);
        plan(OP_DELETE, 32'sh8000_0000, 7'd0);
        plan(OP_DELETE, 32'sh7fff_ffff, 7'd0);
        plan(t_op'(OP_UNUSED), -32'sd1, 7'd127);
        plan(OP_READ, 32'sd0, 7'd3);
        plan(OP_READ, 32'sd0, 7'd0);

        n_rand = 0;
        while (n_rand < N_RANDOM) begin
            if (n_rand == 0) begin
                kind = 0;
                len  = 260;
            end else if (n_rand == 260) begin
                kind = 1;
                len  = 260;
            end else begin
                kind = $urandom_range(0, 2);
                len  = $urandom_range(40, 250);
            end
            for (int j = 0; j < len && n_rand < N_RANDOM; j++) begin
                r = $urandom_range(0, 99);
                case (kind)
                    0: op = (r < 75) ? OP_INSERT : (r < 85) ? OP_DELETE :
                            (r < 97) ? OP_READ : t_op'(OP_UNUSED);
                    1: op = (r < 15) ? OP_INSERT : (r < 85) ? OP_DELETE :
                            (r < 97) ? OP_READ : t_op'(OP_UNUSED);
                    default: op = (r < 40) ? OP_INSERT : (r < 70) ? OP_DELETE :
                                  (r < 97) ? OP_READ : t_op'(OP_UNUSED);
                endcase
                v  = pick_value();
                ix = 7'($urandom_range(0, 127));
                if (op == OP_DELETE && held_vals.size() > 0 && $urandom_range(0, 99) < 75) begin
                    v = held_vals[$urandom_range(0, held_vals.size() - 1)];
                end
                if (op == OP_READ && held_vals.size() > 0 && $urandom_range(0, 99) < 85) begin
                    ix = 7'($urandom_range(0, held_vals.size() - 1));
                end
                plan(op, v, ix);
                n_rand++;
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() > 0 || in_valid || results_due.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
